[rtl/compressor_thermostat_lockout_defines.svh]
// ----------------------------------------------------------------------------
// Thermostat lockout assertion macros
// Shared property wrappers for the checker of the thermostat block.
// ----------------------------------------------------------------------------
`ifndef COMPRESSOR_THERMOSTAT_LOCKOUT_DEFINES_SVH
`define COMPRESSOR_THERMOSTAT_LOCKOUT_DEFINES_SVH

// Property checked outside of reset.
`define CTL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked through reset as well.
`define CTL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/ctl_pkg.sv]
// ----------------------------------------------------------------------------
// Thermostat lockout package
// Widths, register map, reset values and codes shared by the thermostat block.
// ----------------------------------------------------------------------------
`default_nettype none

package ctl_pkg;

    localparam int TEMP_WIDTH_DEF  = 12;
    localparam int TIMER_WIDTH_DEF = 20;

    localparam int HYST_W     = 10;
    localparam int MIN_OFF_W  = 20;
    localparam int BTN_LOCK_W = 16;
    localparam int BTN_CNT_W  = 17;
    localparam int REQ_W      = 2;
    localparam int ACT_W      = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_IDX_W  = 2;

    // Register indexes (byte address = 4 * index)
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_TARGET  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_OFF      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BTN_LOCKOUT  = 2'd3;

    // Reset values
    localparam int TEMP_TARGET_RST = -288;
    localparam int HYST_RST        = 16;
    localparam int MIN_OFF_RST     = 300000;
    localparam int BTN_LOCK_RST    = 200;

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_BUTTON = 2'd2;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE    = 3'd0,
        ACT_STARTED = 3'd1,
        ACT_STOPPED = 3'd2,
        ACT_HELD    = 3'd3,
        ACT_IGNORED = 3'd4
    } t_action;

endpackage

`default_nettype wire

[rtl/ctl_regs.sv]
// ----------------------------------------------------------------------------
// Thermostat configuration registers
// APB register file holding target, hysteresis, minimum off time and lockout.
// ----------------------------------------------------------------------------
`default_nettype none

module ctl_regs #(
    parameter int TEMP_WIDTH = ctl_pkg::TEMP_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [ctl_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [ctl_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [ctl_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                  pready,
    output logic      [TEMP_WIDTH-1:0]            o_temp_target,
    output logic      [ctl_pkg::HYST_W-1:0]       o_hysteresis_band,
    output logic      [ctl_pkg::MIN_OFF_W-1:0]    o_min_off_ms,
    output logic      [ctl_pkg::BTN_LOCK_W-1:0]   o_button_lockout_ms
);
    import ctl_pkg::*;

    logic [TEMP_WIDTH-1:0]  r_temp_target;
    logic [HYST_W-1:0]      r_hyst;
    logic [MIN_OFF_W-1:0]   r_min_off;
    logic [BTN_LOCK_W-1:0]  r_btn_lock;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic                   wr_en;

    assign pready = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_en = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_target <= TEMP_WIDTH'(TEMP_TARGET_RST);
            r_hyst        <= HYST_W'(HYST_RST);
            r_min_off     <= MIN_OFF_W'(MIN_OFF_RST);
            r_btn_lock    <= BTN_LOCK_W'(BTN_LOCK_RST);
        end else if (wr_en) begin
            case (reg_idx)
                REG_TEMP_TARGET: r_temp_target <= pwdata[TEMP_WIDTH-1:0];
                REG_HYSTERESIS:  r_hyst        <= pwdata[HYST_W-1:0];
                REG_MIN_OFF:     r_min_off     <= pwdata[MIN_OFF_W-1:0];
                REG_BTN_LOCKOUT: r_btn_lock    <= pwdata[BTN_LOCK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TEMP_TARGET: prdata = CFG_DATA_W'(r_temp_target);
            REG_HYSTERESIS:  prdata = CFG_DATA_W'(r_hyst);
            REG_MIN_OFF:     prdata = CFG_DATA_W'(r_min_off);
            REG_BTN_LOCKOUT: prdata = CFG_DATA_W'(r_btn_lock);
            default:         prdata = '0;
        endcase
    end

    assign o_temp_target       = r_temp_target;
    assign o_hysteresis_band   = r_hyst;
    assign o_min_off_ms        = r_min_off;
    assign o_button_lockout_ms = r_btn_lock;

endmodule

`default_nettype wire

[rtl/compressor_thermostat_lockout.sv]
// A result passes through the input register and then the result register
// before it is presented.
// Throughput: one item per cycle while results are taken; results leave in
// input order, and a stalled result holds the input stage until it leaves.
// Reset (synchronous, active low): compressor off, both timers zero, lockout
// active, configuration back to its defaults, both pipeline stages empty.
// ----------------------------------------------------------------------------
// Compressor thermostat with anti-short-cycle lockout
// Bang-bang control on temperature samples, minimum off time, button toggle.
// ----------------------------------------------------------------------------
`default_nettype none

module compressor_thermostat_lockout #(
    parameter int TEMP_WIDTH  = ctl_pkg::TEMP_WIDTH_DEF,
    parameter int TIMER_WIDTH = ctl_pkg::TIMER_WIDTH_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // tdata: temp_sample [TEMP_WIDTH-1:0], button_low [TEMP_WIDTH], zero pad
    input  wire logic [((TEMP_WIDTH+8)/8)*8-1:0]        s_axis_tdata,
    // tuser: req_type [1:0]
    input  wire logic [ctl_pkg::REQ_W-1:0]              s_axis_tuser,
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // tdata: compressor_on [0], action [3:1], lockout_active [4], zero pad
    output logic      [7:0]                             m_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [ctl_pkg::CFG_ADDR_W-1:0]         paddr,
    input  wire logic [ctl_pkg::CFG_DATA_W-1:0]         pwdata,
    output logic      [ctl_pkg::CFG_DATA_W-1:0]         prdata,
    output logic                                        pready
);
    import ctl_pkg::*;

    localparam int CW   = ((TEMP_WIDTH > HYST_W + 1) ? TEMP_WIDTH : HYST_W + 1) + 1;
    localparam int OFFW = (TIMER_WIDTH > MIN_OFF_W) ? TIMER_WIDTH : MIN_OFF_W;

    logic [TEMP_WIDTH-1:0]  cfg_target;
    logic [HYST_W-1:0]      cfg_hyst;
    logic [MIN_OFF_W-1:0]   cfg_min_off;
    logic [BTN_LOCK_W-1:0]  cfg_btn_lock;

    ctl_regs #(
        .TEMP_WIDTH (TEMP_WIDTH)
    ) u_regs (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .o_temp_target       (cfg_target),
        .o_hysteresis_band   (cfg_hyst),
        .o_min_off_ms        (cfg_min_off),
        .o_button_lockout_ms (cfg_btn_lock)
    );

    // Input stage
    logic                   r_in_valid;
    logic [REQ_W-1:0]       r_in_req;
    logic [TEMP_WIDTH-1:0]  r_in_temp;
    logic                   r_in_btn;

    // Controller state
    logic                   r_running;
    logic [TIMER_WIDTH-1:0] r_off_ms;
    logic [BTN_CNT_W-1:0]   r_btn_ms;

    // Result stage
    logic                   r_out_valid;
    logic                   r_out_on;
    t_action                r_out_act;
    logic                   r_out_lock;

    logic                   advance;
    logic                   fire;
    logic                   n_running;
    logic [TIMER_WIDTH-1:0] n_off_ms;
    logic [BTN_CNT_W-1:0]   n_btn_ms;
    t_action                n_act;
    logic                   n_lock;
    logic signed [CW-1:0]   temp_x;
    logic signed [CW-1:0]   thr_hi;
    logic signed [CW-1:0]   thr_lo;
    logic                   start_ok;

    assign advance       = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_req  <= s_axis_tuser;
            r_in_temp <= s_axis_tdata[TEMP_WIDTH-1:0];
            r_in_btn  <= s_axis_tdata[TEMP_WIDTH];
        end
    end

    // Exact thresholds at a width that cannot overflow
    always_comb begin
        temp_x = CW'(signed'(r_in_temp));
        thr_hi = CW'(signed'(cfg_target)) + signed'(CW'(cfg_hyst));
        thr_lo = CW'(signed'(cfg_target)) - signed'(CW'(cfg_hyst));
    end

    assign start_ok = OFFW'(r_off_ms) >= OFFW'(cfg_min_off);

    always_comb begin
        n_running = r_running;
        n_off_ms  = r_off_ms;
        n_btn_ms  = r_btn_ms;
        n_act     = ACT_NONE;
        case (r_in_req)
            REQ_TICK: begin
                if (r_off_ms != '1) begin
                    n_off_ms = r_off_ms + 1'b1;
                end
                if (r_btn_ms != '1) begin
                    n_btn_ms = r_btn_ms + 1'b1;
                end
            end
            REQ_SAMPLE: begin
                if (temp_x > thr_hi) begin
                    if (!r_running) begin
                        if (start_ok) begin
                            n_running = 1'b1;
                            n_act     = ACT_STARTED;
                        end else begin
                            n_act = ACT_HELD;
                        end
                    end
                end else if (temp_x < thr_lo) begin
                    // stop restarts the off timer even when already off
                    n_running = 1'b0;
                    n_off_ms  = '0;
                    n_act     = ACT_STOPPED;
                end
            end
            REQ_BUTTON: begin
                if (r_btn_ms > BTN_CNT_W'(cfg_btn_lock)) begin
                    n_btn_ms = '0;
                    if (!r_in_btn) begin
                        n_act = ACT_IGNORED;
                    end else if (r_running) begin
                        n_running = 1'b0;
                        n_off_ms  = '0;
                        n_act     = ACT_STOPPED;
                    end else if (start_ok) begin
                        n_running = 1'b1;
                        n_act     = ACT_STARTED;
                    end else begin
                        n_act = ACT_HELD;
                    end
                end else begin
                    n_act = ACT_IGNORED;
                end
            end
            default: ;
        endcase
        n_lock = !n_running && (OFFW'(n_off_ms) < OFFW'(cfg_min_off));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_off_ms  <= '0;
            r_btn_ms  <= '0;
        end else if (fire) begin
            r_running <= n_running;
            r_off_ms  <= n_off_ms;
            r_btn_ms  <= n_btn_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_on   <= n_running;
            r_out_act  <= n_act;
            r_out_lock <= n_lock;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_lock, r_out_act, r_out_on};

endmodule

`default_nettype wire

[rtl/ctl_assert.sv]
// ----------------------------------------------------------------------------
// Thermostat lockout port checker
// Watches result transactions for consistency between drive, action and lockout.
// ----------------------------------------------------------------------------
`default_nettype none

`include "compressor_thermostat_lockout_defines.svh"

module ctl_assert (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_m_tvalid,
    input  wire logic       i_m_tready,
    input  wire logic [7:0] i_m_tdata
);
    import ctl_pkg::*;

    logic    on_bit;
    logic    lock_bit;
    t_action act;

    assign on_bit   = i_m_tdata[0];
    assign lock_bit = i_m_tdata[4];
    assign act      = t_action'(i_m_tdata[3:1]);

    // Lockout only ever shows while the compressor is off
    `CTL_ASSERT(a_lock_when_off, i_m_tvalid |-> !(on_bit && lock_bit), "lockout shown while running")

    `CTL_ASSERT(a_start_runs, (i_m_tvalid && act == ACT_STARTED) |-> on_bit, "started but relay off")

    `CTL_ASSERT(a_held_locked, (i_m_tvalid && act == ACT_HELD) |-> (!on_bit && lock_bit), "start held without lockout")

    // A stalled result must not change under backpressure
    `CTL_ASSERT(a_hold_stall, (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata)), "result changed while stalled")

    `CTL_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !i_m_tvalid, "result valid after reset")

endmodule

bind compressor_thermostat_lockout ctl_assert u_ctl_assert (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);

`default_nettype wire

[sim/tb_compressor_thermostat_lockout.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermostat lockout testbench
// Drives ticks, temperature samples and button presses into the stream input,
// tracks the expected relay state, action and lockout flag with a local model
// of the controller, and checks every output transaction in order. A short
// table of hand-picked cases runs first, then random phases with different
// register settings and different amounts of sender and receiver idling.
// ----------------------------------------------------------------------------

module tb_compressor_thermostat_lockout;

    import ctl_pkg::*;

    localparam int TW     = TEMP_WIDTH_DEF;
    localparam int TDW    = ((TW + 8) / 8) * 8;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 285;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic    compressor_on;
        t_action action;
        logic    lockout_active;
    } status_t;

    typedef struct packed {
        logic                 is_write;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [31:0]          wdata;
        logic [REQ_W-1:0]     req;
        logic [TW-1:0]        temp;
        logic                 pin_low;
        logic                 known;
        status_t              status;
    } stim_row_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic [TDW-1:0]         s_axis_tdata;
    logic [REQ_W-1:0]       s_axis_tuser;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [CFG_ADDR_W-1:0]  paddr;
    logic [CFG_DATA_W-1:0]  pwdata;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    compressor_thermostat_lockout u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Model of the controller: registers and state
    logic signed [TW-1:0]      cfg_target;
    logic [HYST_W-1:0]         cfg_hyst;
    logic [MIN_OFF_W-1:0]      cfg_min_off;
    logic [BTN_LOCK_W-1:0]     cfg_btn_lock;
    logic                      running;
    logic [TIMER_WIDTH_DEF-1:0] off_ms;
    logic [BTN_CNT_W-1:0]      btn_ms;

    status_t pending_status[$];
    int      mismatch_cnt;
    int      items_in;
    int      results_out;
    int      action_seen[5];

    int      idle_pct;
    int      stall_pct;
    logic    drv_known;
    status_t drv_status;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at result %0d: %s got %0h want %0h",
                 results_out, what, got, want);
        mismatch_cnt++;
    endtask

    function automatic t_action start_compressor();
        if (running)
            return ACT_NONE;
        if (off_ms < cfg_min_off)
            return ACT_HELD;
        running = 1'b1;
        return ACT_STARTED;
    endfunction

    function automatic t_action stop_compressor();
        running = 1'b0;
        off_ms  = '0;
        return ACT_STOPPED;
    endfunction

    function automatic status_t thermostat_step(input logic [REQ_W-1:0] req,
                                                input logic signed [TW-1:0] temp,
                                                input logic pin_low);
        status_t r;
        int      t;
        int      hi;
        int      lo;
        t  = int'(temp);
        hi = int'(cfg_target) + int'(cfg_hyst);
        lo = int'(cfg_target) - int'(cfg_hyst);
        r.action = ACT_NONE;
        case (req)
            REQ_TICK: begin
                if (off_ms != '1) off_ms = off_ms + 1'b1;
                if (btn_ms != '1) btn_ms = btn_ms + 1'b1;
            end
            REQ_SAMPLE: begin
                if (t > hi)
                    r.action = start_compressor();
                else if (t < lo)
                    r.action = stop_compressor();
            end
            REQ_BUTTON: begin
                if (btn_ms > {1'b0, cfg_btn_lock}) begin
                    btn_ms = '0;
                    if (!pin_low)
                        r.action = ACT_IGNORED;
                    else if (running)
                        r.action = stop_compressor();
                    else
                        r.action = start_compressor();
                end else begin
                    r.action = ACT_IGNORED;
                end
            end
            default: ;
        endcase
        r.compressor_on  = running;
        r.lockout_active = !running && (off_ms < cfg_min_off);
        return r;
    endfunction

    // Track register writes, predict accepted items, check results
    always @(posedge i_clk) begin
        status_t s;
        if (!i_rst_n) begin
            cfg_target   = TW'(TEMP_TARGET_RST);
            cfg_hyst     = HYST_W'(HYST_RST);
            cfg_min_off  = MIN_OFF_W'(MIN_OFF_RST);
            cfg_btn_lock = BTN_LOCK_W'(BTN_LOCK_RST);
            running      = 1'b0;
            off_ms       = '0;
            btn_ms       = '0;
            pending_status.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[CFG_IDX_W+1:2])
                    REG_TEMP_TARGET: cfg_target   = pwdata[TW-1:0];
                    REG_HYSTERESIS:  cfg_hyst     = pwdata[HYST_W-1:0];
                    REG_MIN_OFF:     cfg_min_off  = pwdata[MIN_OFF_W-1:0];
                    REG_BTN_LOCKOUT: cfg_btn_lock = pwdata[BTN_LOCK_W-1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_status.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata, '0);
                end else begin
                    s = pending_status.pop_front();
                    if (m_axis_tdata[0] !== s.compressor_on)
                        report_mismatch("compressor_on", m_axis_tdata[0], s.compressor_on);
                    if (m_axis_tdata[3:1] !== s.action)
                        report_mismatch("action", m_axis_tdata[3:1], s.action);
                    if (m_axis_tdata[4] !== s.lockout_active)
                        report_mismatch("lockout_active", m_axis_tdata[4],
                                        s.lockout_active);
                end
                if (m_axis_tdata[3:1] < 3'd5)
                    action_seen[m_axis_tdata[3:1]]++;
                results_out++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                s = thermostat_step(s_axis_tuser, s_axis_tdata[TW-1:0], s_axis_tdata[TW]);
                // hand-typed expectations take the place of the prediction
                if (drv_known)
                    s = drv_status;
                pending_status.push_back(s);
                items_in++;
            end
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready = ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic send_item(input logic [REQ_W-1:0] req, input logic [TW-1:0] temp,
                             input logic pin_low, input logic known,
                             input status_t status);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata      = '0;
        s_axis_tdata[TW-1:0] = temp;
        s_axis_tdata[TW]  = pin_low;
        s_axis_tuser      = req;
        drv_known         = known;
        drv_status        = status;
        s_axis_tvalid     = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Hold the input until every pending result has left the block
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        drain_results();
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic stim_row_t mk_item(input logic [REQ_W-1:0] req,
                                          input logic [TW-1:0] temp, input logic pin_low);
        stim_row_t r;
        r         = '0;
        r.req     = req;
        r.temp    = temp;
        r.pin_low = pin_low;
        return r;
    endfunction

    function automatic stim_row_t mk_checked(input logic [REQ_W-1:0] req,
                                             input logic [TW-1:0] temp, input logic pin_low,
                                             input logic on, input t_action act,
                                             input logic lock);
        stim_row_t r;
        r        = mk_item(req, temp, pin_low);
        r.known  = 1'b1;
        r.status = '{compressor_on: on, action: act, lockout_active: lock};
        return r;
    endfunction

    function automatic stim_row_t mk_write(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [31:0] val);
        stim_row_t r;
        r          = '0;
        r.is_write = 1'b1;
        r.reg_idx  = idx;
        r.wdata    = val;
        return r;
    endfunction

    initial begin
        stim_row_t plan[$];
        int        iter;
        int        n;
        int        burst;
        int        k;
        int        t;
        int        p_tgt;
        int        p_hyst;
        int        p_min;
        int        p_lock;

        i_rst_n       = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_TICK;
        s_axis_tvalid = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        drv_known     = 1'b0;
        drv_status    = '0;
        idle_pct      = 0;
        stall_pct     = 0;
        mismatch_cnt  = 0;
        items_in      = 0;
        results_out   = 0;
        foreach (action_seen[i]) action_seen[i] = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // defaults: target -288, band 16, long minimum off time
        plan.push_back(mk_checked(REQ_TICK, 12'h000, 1'b0, 1'b0, ACT_NONE, 1'b1));
        plan.push_back(mk_checked(REQ_SAMPLE, 12'h7FF, 1'b0, 1'b0, ACT_HELD, 1'b1));
        plan.push_back(mk_checked(REQ_SAMPLE, 12'h800, 1'b1, 1'b0, ACT_STOPPED, 1'b1));
        plan.push_back(mk_item(REQ_SAMPLE, -12'sd272, 1'b0));
        plan.push_back(mk_item(REQ_SAMPLE, -12'sd271, 1'b0));
        plan.push_back(mk_item(REQ_SAMPLE, -12'sd304, 1'b0));
        plan.push_back(mk_item(REQ_SAMPLE, -12'sd305, 1'b0));
        plan.push_back(mk_item(REQ_BUTTON, 12'h000, 1'b1));
        plan.push_back(mk_checked(REQ_UNUSED, 12'hFFF, 1'b1, 1'b0, ACT_NONE, 1'b1));
        // upper bits beyond the register width are dropped
        plan.push_back(mk_write(REG_MIN_OFF, 32'hFFF0_0000));
        plan.push_back(mk_write(REG_BTN_LOCKOUT, 32'h0));
        plan.push_back(mk_item(REQ_TICK, 12'hABC, 1'b1));
        plan.push_back(mk_item(REQ_SAMPLE, 12'h7FF, 1'b0));
        plan.push_back(mk_item(REQ_SAMPLE, 12'h7FF, 1'b0));
        plan.push_back(mk_item(REQ_BUTTON, 12'h000, 1'b1));
        plan.push_back(mk_item(REQ_BUTTON, 12'h000, 1'b1));
        plan.push_back(mk_item(REQ_TICK, 12'h000, 1'b0));
        plan.push_back(mk_item(REQ_BUTTON, 12'h555, 1'b0));
        plan.push_back(mk_item(REQ_TICK, 12'h000, 1'b0));
        plan.push_back(mk_item(REQ_BUTTON, 12'h000, 1'b1));
        plan.push_back(mk_write(REG_MIN_OFF, 32'h000F_FFFF));
        plan.push_back(mk_checked(REQ_SAMPLE, 12'h800, 1'b0, 1'b0, ACT_STOPPED, 1'b1));
        plan.push_back(mk_item(REQ_TICK, 12'h000, 1'b0));
        plan.push_back(mk_item(REQ_BUTTON, 12'h000, 1'b1));
        plan.push_back(mk_write(REG_TEMP_TARGET, 32'h0000_07FF));
        plan.push_back(mk_write(REG_HYSTERESIS, 32'h0000_03FF));
        plan.push_back(mk_item(REQ_SAMPLE, 12'h7FF, 1'b0));
        plan.push_back(mk_item(REQ_SAMPLE, 12'h800, 1'b0));
        plan.push_back(mk_write(REG_TEMP_TARGET, 32'hFFFF_F800));
        plan.push_back(mk_write(REG_HYSTERESIS, 32'h0));
        plan.push_back(mk_item(REQ_SAMPLE, 12'h800, 1'b0));
        plan.push_back(mk_item(REQ_SAMPLE, 12'h801, 1'b0));

        foreach (plan[i]) begin
            if (plan[i].is_write)
                write_reg(plan[i].reg_idx, plan[i].wdata);
            else
                send_item(plan[i].req, plan[i].temp, plan[i].pin_low, plan[i].known,
                          plan[i].status);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            idle_pct  = 0;
            stall_pct = 0;
            case (ph)
                1: begin
                    p_tgt  = int'($urandom_range(0, 800)) - 400;
                    p_hyst = 0;
                    p_min  = 0;
                    p_lock = 0;
                end
                2: begin
                    p_tgt  = 2047;
                    p_hyst = 1023;
                    p_min  = 1048575;
                    p_lock = 65535;
                end
                3: begin
                    p_tgt  = -2048;
                    p_hyst = $urandom_range(0, 8);
                    p_min  = $urandom_range(0, 30);
                    p_lock = $urandom_range(0, 10);
                end
                default: begin
                    p_tgt  = int'($urandom_range(0, 800)) - 400;
                    p_hyst = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                         : $urandom_range(0, 40);
                    p_min  = $urandom_range(0, (ph < 4) ? 30 : 200);
                    p_lock = $urandom_range(0, (ph < 4) ? 20 : 50);
                end
            endcase
            write_reg(REG_TEMP_TARGET, p_tgt);
            write_reg(REG_HYSTERESIS, p_hyst);
            write_reg(REG_MIN_OFF, p_min);
            write_reg(REG_BTN_LOCKOUT, p_lock);

            case (ph % 4)
                1: idle_pct = 57;
                2: stall_pct = 57;
                3: begin
                    idle_pct  = 15;
                    stall_pct = 15;
                end
                default: ;
            endcase

            n    = 0;
            iter = 0;
            while (n < PHASE_ITEMS) begin
                k = $urandom_range(0, 99);
                if (k < 45) begin
                    // run of ticks so the off timer gets past its minimum
                    burst = $urandom_range(1, 12);
                    repeat (burst)
                        send_item(REQ_TICK, TW'($urandom), 1'($urandom), 1'b0, '0);
                    n += burst;
                end else if (k < 75) begin
                    case ($urandom_range(0, 3))
                        0: t = $urandom_range(0, 4095);
                        1: t = int'(cfg_target) + int'(cfg_hyst) + $urandom_range(0, 2) - 1;
                        2: t = int'(cfg_target) - int'(cfg_hyst) + $urandom_range(0, 2) - 1;
                        default: t = int'(cfg_target) + $urandom_range(0, 64) - 32;
                    endcase
                    send_item(REQ_SAMPLE, t[TW-1:0], 1'($urandom), 1'b0, '0);
                    n++;
                end else if (k < 96) begin
                    send_item(REQ_BUTTON, TW'($urandom), ($urandom_range(0, 3) != 0),
                              1'b0, '0);
                    n++;
                end else begin
                    send_item(REQ_UNUSED, TW'($urandom), 1'($urandom), 1'b0, '0);
                    n++;
                end
                iter++;
                if (iter % 60 == 59)
                    drain_results();
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (pending_status.size() != 0)
            report_mismatch("results missing", pending_status.size(), 0);
        $display("summary: %0d items in, %0d results out over %0d register phases",
                 items_in, results_out, PHASES + 1);
        $display("summary: started %0d stopped %0d held %0d ignored %0d none %0d",
                 action_seen[ACT_STARTED], action_seen[ACT_STOPPED],
                 action_seen[ACT_HELD], action_seen[ACT_IGNORED], action_seen[ACT_NONE]);
        if (mismatch_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
